// File: src/assert_macros.svh
// Assertion macros for the complex arithmetic unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define CAU_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define CAU_ASSERT_IMP(label, clk, rst, a, b)
`define CAU_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

// File: src/cau_pkg.sv
// Shared constants and types for the complex arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_SUB   = 3'd1;
  localparam logic [2:0] MODE_MUL   = 3'd2;
  localparam logic [2:0] MODE_SCALE = 3'd3;
  localparam logic [2:0] MODE_CONJ  = 3'd4;
  localparam logic [2:0] MODE_NEG   = 3'd5;
  localparam logic [2:0] MODE_DIV   = 3'd6;
  localparam logic [2:0] MODE_MAG   = 3'd7;

  typedef struct packed {
    logic       valid;
    logic [2:0] mode;
    logic       dbz;
    logic       dovf;
    logic       neg_r;
    logic       neg_i;
    logic       qov_r;
    logic       qov_i;
  } ctl_t;

endpackage

// File: src/cau_iter.sv
// One pipeline stage of the iterative part: a restoring divide step for
// both quotient lanes and one digit of the square root. Uses cau_pkg.
`timescale 1ns / 1ps

module cau_iter #(
  parameter int EW = cau_pkg::WORD_BITS_DEF,
  parameter int K  = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cau_pkg::ctl_t       ctl_i,
  output cau_pkg::ctl_t       ctl_o,
  input  logic [2*EW-1:0]     d_i,
  output logic [2*EW-1:0]     d_o,
  input  logic [2*EW-1:0]     rr_i,
  output logic [2*EW-1:0]     rr_o,
  input  logic [2*EW-1:0]     ri_i,
  output logic [2*EW-1:0]     ri_o,
  input  logic [EW:0]         qr_i,
  output logic [EW:0]         qr_o,
  input  logic [EW:0]         qi_i,
  output logic [EW:0]         qi_o,
  input  logic [EW:0]         xr_i,
  output logic [EW:0]         xr_o,
  input  logic [EW:0]         xi_i,
  output logic [EW:0]         xi_o,
  input  logic [2*EW+1:0]     sn_i,
  output logic [2*EW+1:0]     sn_o,
  input  logic [EW+2:0]       srem_i,
  output logic [EW+2:0]       srem_o,
  input  logic [EW:0]         sroot_i,
  output logic [EW:0]         sroot_o,
  input  logic [EW-1:0]       dyr_i,
  output logic [EW-1:0]       dyr_o,
  input  logic [EW-1:0]       dyi_i,
  output logic [EW-1:0]       dyi_o
);

  localparam int PW = 2 * EW;
  localparam int RW = EW + 3;

  logic [PW:0]   tr, ti, dr_diff, di_diff;
  logic          ger, gei;
  logic [RW+1:0] st, trial, s_diff;
  logic          ges;

  always_comb begin
    tr      = {rr_i, xr_i[K]};
    ti      = {ri_i, xi_i[K]};
    dr_diff = tr - {1'b0, d_i};
    di_diff = ti - {1'b0, d_i};
    ger     = tr >= {1'b0, d_i};
    gei     = ti >= {1'b0, d_i};
    st      = {srem_i, sn_i[2*K+1 -: 2]};
    trial   = (RW + 2)'({sroot_i, 2'b01});
    s_diff  = st - trial;
    ges     = st >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o     <= d_i;
      rr_o    <= ger ? dr_diff[PW-1:0] : tr[PW-1:0];
      ri_o    <= gei ? di_diff[PW-1:0] : ti[PW-1:0];
      qr_o    <= {qr_i[EW-1:0], ger};
      qi_o    <= {qi_i[EW-1:0], gei};
      xr_o    <= xr_i;
      xi_o    <= xi_i;
      sn_o    <= sn_i;
      srem_o  <= ges ? s_diff[RW-1:0] : st[RW-1:0];
      sroot_o <= {sroot_i[EW-1:0], ges};
      dyr_o   <= dyr_i;
      dyi_o   <= dyi_i;
    end
  end

endmodule

// File: src/complex_arithmetic_unit_top.sv
// Complex arithmetic unit, top level: operand prep, multipliers, divider
// and square root pipeline, output skid. Uses cau_pkg, cau_iter, assert_macros.svh.
//
// Usage: one input beat carries mode, operands a and b and a real scalar,
// all signed Q16.16 by default. Each input beat gives exactly one output
// beat with y_real, y_imag, divide_by_zero and overflow, in order.
// Channels use valid/stall; a beat moves when valid is high and stall low.
// Throughput is one beat per cycle in every mode while in_stall is low. The
// pipeline is made of the one-bit-per-stage divider and square root chain of
// WORD_BITS+1 stages plus eight stages of operand prep, multiply, sum,
// normalize and saturate.
// When the receiver stalls, the output register holds its beat and one more
// beat lands in a skid register; in_stall then rises and the whole pipeline
// freezes without losing or repeating a beat.
// Reset clears all valid bits; the first beat may be sent the cycle after.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module complex_arithmetic_unit_top #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic signed [31:0] a_real,
  input  logic signed [31:0] a_imag,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_imag,
  input  logic signed [31:0] scalar,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] y_real,
  output logic signed [31:0] y_imag,
  output logic               divide_by_zero,
  output logic               overflow
);

  localparam int EW = (WORD_BITS > 32) ? 32 : WORD_BITS;
  localparam int FB = FRAC_BITS;
  localparam int PW = 2 * EW;
  localparam int SW = PW + 1;
  localparam int XW = PW + FB;
  localparam int NI = EW + 1;
  localparam int NW = 2 * NI;
  localparam int RW = EW + 3;

  localparam logic signed [SW-1:0] SMAX = {{(SW-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-EW+1){1'b1}}, {(EW-1){1'b0}}};
  localparam logic [EW:0] LIM   = {2'b01, {(EW-1){1'b0}}};
  localparam logic [EW:0] LIMM1 = {2'b00, {(EW-1){1'b1}}};
  localparam logic [EW:0] CAP   = {2'b01, {(EW-2){1'b0}}, 1'b1};

  logic en;
  logic skid_v;

  assign en       = !skid_v;
  assign in_stall = skid_v;

  function automatic logic [EW-1:0] absv(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] n;
    n = -v;
    return v[EW-1] ? n : v;
  endfunction

  function automatic logic [EW:0] sat_s(input logic signed [SW-1:0] v);
    logic [EW:0] r;
    if (v > SMAX) begin
      r = {1'b1, SMAX[EW-1:0]};
    end else if (v < SMIN) begin
      r = {1'b1, SMIN[EW-1:0]};
    end else begin
      r = {1'b0, v[EW-1:0]};
    end
    return r;
  endfunction

  function automatic logic [EW:0] sat_m(input logic [EW:0] m, input logic neg);
    logic [EW:0] nm;
    logic [EW:0] r;
    nm = -m;
    if (neg) begin
      r = (m > LIM) ? {1'b1, LIM[EW-1:0]} : {1'b0, nm[EW-1:0]};
    end else begin
      r = (m > LIMM1) ? {1'b1, LIMM1[EW-1:0]} : {1'b0, m[EW-1:0]};
    end
    return r;
  endfunction

  function automatic logic signed [SW-1:0] sgnd(input logic [PW-1:0] p, input logic s);
    logic signed [SW-1:0] t;
    t = signed'({1'b0, p});
    return s ? -t : t;
  endfunction

  // stage A: capture
  logic                 va;
  logic [2:0]           a_mode;
  logic signed [EW-1:0] a_ar, a_ai, a_br, a_bi, a_sc;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode <= mode;
      a_ar   <= a_real[EW-1:0];
      a_ai   <= a_imag[EW-1:0];
      a_br   <= b_real[EW-1:0];
      a_bi   <= b_imag[EW-1:0];
      a_sc   <= scalar[EW-1:0];
    end
  end

  // stage B: magnitudes, operand select, simple results
  logic                 vb;
  logic [2:0]           b_mode;
  logic                 b_dbz;
  logic [EW-1:0]        b_aar, b_aai, b_abr, b_abi, b_m0, b_m1;
  logic                 b_s0, b_s1, b_s2, b_s3;
  logic signed [EW:0]   b_sr, b_si;
  logic signed [EW:0]   sr_c, si_c, ear, eai, ebr, ebi;
  logic [EW-1:0]        m0_c, m1_c;
  logic                 s0b_c, s1b_c;

  always_comb begin
    ear  = {a_ar[EW-1], a_ar};
    eai  = {a_ai[EW-1], a_ai};
    ebr  = {a_br[EW-1], a_br};
    ebi  = {a_bi[EW-1], a_bi};
    case (a_mode)
      cau_pkg::MODE_ADD: begin
        sr_c = ear + ebr;
        si_c = eai + ebi;
      end
      cau_pkg::MODE_SUB: begin
        sr_c = ear - ebr;
        si_c = eai - ebi;
      end
      cau_pkg::MODE_CONJ: begin
        sr_c = ear;
        si_c = -eai;
      end
      cau_pkg::MODE_NEG: begin
        sr_c = -ear;
        si_c = -eai;
      end
      default: begin
        sr_c = '0;
        si_c = '0;
      end
    endcase
    case (a_mode)
      cau_pkg::MODE_SCALE: begin
        m0_c  = absv(a_sc);
        m1_c  = absv(a_sc);
        s0b_c = a_sc[EW-1];
        s1b_c = a_sc[EW-1];
      end
      cau_pkg::MODE_MAG: begin
        m0_c  = absv(a_ar);
        m1_c  = absv(a_ai);
        s0b_c = a_ar[EW-1];
        s1b_c = a_ai[EW-1];
      end
      default: begin
        m0_c  = absv(a_br);
        m1_c  = absv(a_bi);
        s0b_c = a_br[EW-1];
        s1b_c = a_bi[EW-1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mode <= a_mode;
      b_dbz  <= (a_mode == cau_pkg::MODE_DIV) && (a_br == '0) && (a_bi == '0);
      b_aar  <= absv(a_ar);
      b_aai  <= absv(a_ai);
      b_abr  <= absv(a_br);
      b_abi  <= absv(a_bi);
      b_m0   <= m0_c;
      b_m1   <= m1_c;
      b_s0   <= a_ar[EW-1] ^ s0b_c;
      b_s1   <= a_ai[EW-1] ^ s1b_c;
      b_s2   <= a_ar[EW-1] ^ a_bi[EW-1];
      b_s3   <= a_ai[EW-1] ^ a_br[EW-1];
      b_sr   <= sr_c;
      b_si   <= si_c;
    end
  end

  // stage C: products
  logic               vc;
  logic [2:0]         c_mode;
  logic               c_dbz;
  logic [PW-1:0]      c_p0, c_p1, c_p2, c_p3, c_p4, c_p5;
  logic               c_s0, c_s1, c_s2, c_s3;
  logic signed [EW:0] c_sr, c_si;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mode <= b_mode;
      c_dbz  <= b_dbz;
      c_p0   <= PW'(b_aar) * PW'(b_m0);
      c_p1   <= PW'(b_aai) * PW'(b_m1);
      c_p2   <= PW'(b_aar) * PW'(b_abi);
      c_p3   <= PW'(b_aai) * PW'(b_abr);
      c_p4   <= PW'(b_abr) * PW'(b_abr);
      c_p5   <= PW'(b_abi) * PW'(b_abi);
      c_s0   <= b_s0;
      c_s1   <= b_s1;
      c_s2   <= b_s2;
      c_s3   <= b_s3;
      c_sr   <= b_sr;
      c_si   <= b_si;
    end
  end

  // stage D: signed sums
  logic                 vd;
  logic [2:0]           d_mode;
  logic                 d_dbz;
  logic signed [SW-1:0] d_re, d_im;
  logic [PW-1:0]        d_d, d_nsq;
  logic signed [EW:0]   d_sr, d_si;
  logic signed [SW-1:0] q0, q1, q2, q3, re_c, im_c;

  always_comb begin
    q0 = sgnd(c_p0, c_s0);
    q1 = sgnd(c_p1, c_s1);
    q2 = sgnd(c_p2, c_s2);
    q3 = sgnd(c_p3, c_s3);
    case (c_mode)
      cau_pkg::MODE_MUL: begin
        re_c = q0 - q1;
        im_c = q2 + q3;
      end
      cau_pkg::MODE_SCALE: begin
        re_c = q0;
        im_c = q1;
      end
      cau_pkg::MODE_DIV: begin
        re_c = q0 + q1;
        im_c = q3 - q2;
      end
      default: begin
        re_c = '0;
        im_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_mode <= c_mode;
      d_dbz  <= c_dbz;
      d_re   <= re_c;
      d_im   <= im_c;
      d_d    <= c_p4 + c_p5;
      d_nsq  <= c_p0 + c_p1;
      d_sr   <= c_sr;
      d_si   <= c_si;
    end
  end

  // stage E1: direct results saturated, numerator magnitudes
  logic                 ve1;
  logic [2:0]           e1_mode;
  logic                 e1_dbz, e1_dovf, e1_negr, e1_negi;
  logic [PW-1:0]        e1_nmr, e1_nmi, e1_d, e1_nsq;
  logic [EW-1:0]        e1_dyr, e1_dyi;
  logic [EW:0]          satr_c, sati_c;
  logic signed [SW-1:0] ngr_c, ngi_c;

  always_comb begin
    if (d_mode == cau_pkg::MODE_MUL || d_mode == cau_pkg::MODE_SCALE) begin
      satr_c = sat_s(d_re >>> FB);
      sati_c = sat_s(d_im >>> FB);
    end else begin
      satr_c = sat_s(SW'(d_sr));
      sati_c = sat_s(SW'(d_si));
    end
    ngr_c = -d_re;
    ngi_c = -d_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve1 <= 1'b0;
    end else if (en) begin
      ve1 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_mode <= d_mode;
      e1_dbz  <= d_dbz;
      e1_dovf <= satr_c[EW] | sati_c[EW];
      e1_dyr  <= satr_c[EW-1:0];
      e1_dyi  <= sati_c[EW-1:0];
      e1_negr <= d_re[SW-1];
      e1_negi <= d_im[SW-1];
      e1_nmr  <= d_re[SW-1] ? ngr_c[PW-1:0] : d_re[PW-1:0];
      e1_nmi  <= d_im[SW-1] ? ngi_c[PW-1:0] : d_im[PW-1:0];
      e1_d    <= d_d;
      e1_nsq  <= d_nsq;
    end
  end

  // stage E2: divider setup, then the iteration chain
  cau_pkg::ctl_t ctl_s   [0:NI];
  logic [PW-1:0] d_s     [0:NI];
  logic [PW-1:0] rr_s    [0:NI];
  logic [PW-1:0] ri_s    [0:NI];
  logic [EW:0]   qr_s    [0:NI];
  logic [EW:0]   qi_s    [0:NI];
  logic [EW:0]   xr_s    [0:NI];
  logic [EW:0]   xi_s    [0:NI];
  logic [NW-1:0] sn_s    [0:NI];
  logic [RW-1:0] srem_s  [0:NI];
  logic [EW:0]   sroot_s [0:NI];
  logic [EW-1:0] dyr_s   [0:NI];
  logic [EW-1:0] dyi_s   [0:NI];

  logic [XW-1:0] xr_c, xi_c, hr_c, hi_c;
  cau_pkg::ctl_t ctl_c;

  always_comb begin
    xr_c        = XW'(e1_nmr) << FB;
    xi_c        = XW'(e1_nmi) << FB;
    hr_c        = xr_c >> (EW + 1);
    hi_c        = xi_c >> (EW + 1);
    ctl_c.valid = ve1;
    ctl_c.mode  = e1_mode;
    ctl_c.dbz   = e1_dbz;
    ctl_c.dovf  = e1_dovf;
    ctl_c.neg_r = e1_negr;
    ctl_c.neg_i = e1_negi;
    ctl_c.qov_r = hr_c >= XW'(e1_d);
    ctl_c.qov_i = hi_c >= XW'(e1_d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0] <= '0;
    end else if (en) begin
      ctl_s[0] <= ctl_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_s[0]     <= e1_d;
      rr_s[0]    <= hr_c[PW-1:0];
      ri_s[0]    <= hi_c[PW-1:0];
      qr_s[0]    <= '0;
      qi_s[0]    <= '0;
      xr_s[0]    <= xr_c[EW:0];
      xi_s[0]    <= xi_c[EW:0];
      sn_s[0]    <= NW'(e1_nsq);
      srem_s[0]  <= '0;
      sroot_s[0] <= '0;
      dyr_s[0]   <= e1_dyr;
      dyi_s[0]   <= e1_dyi;
    end
  end

  for (genvar j = 0; j < NI; j++) begin : g_iter
    cau_iter #(
      .EW(EW),
      .K (NI - 1 - j)
    ) u_iter (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctl_i  (ctl_s[j]),
      .ctl_o  (ctl_s[j+1]),
      .d_i    (d_s[j]),
      .d_o    (d_s[j+1]),
      .rr_i   (rr_s[j]),
      .rr_o   (rr_s[j+1]),
      .ri_i   (ri_s[j]),
      .ri_o   (ri_s[j+1]),
      .qr_i   (qr_s[j]),
      .qr_o   (qr_s[j+1]),
      .qi_i   (qi_s[j]),
      .qi_o   (qi_s[j+1]),
      .xr_i   (xr_s[j]),
      .xr_o   (xr_s[j+1]),
      .xi_i   (xi_s[j]),
      .xi_o   (xi_s[j+1]),
      .sn_i   (sn_s[j]),
      .sn_o   (sn_s[j+1]),
      .srem_i (srem_s[j]),
      .srem_o (srem_s[j+1]),
      .sroot_i(sroot_s[j]),
      .sroot_o(sroot_s[j+1]),
      .dyr_i  (dyr_s[j]),
      .dyr_o  (dyr_s[j+1]),
      .dyi_i  (dyi_s[j]),
      .dyi_o  (dyi_s[j+1])
    );
  end

  // stage F: final saturation and mode select
  cau_pkg::ctl_t fc;
  logic          f_v, f_dbz, f_ovf;
  logic [EW-1:0] f_yr, f_yi;
  logic [EW:0]   qmr_c, qmi_c, fr_c, fi_c, fs_c;
  logic [EW-1:0] yr_c, yi_c;
  logic          dbz_c, ovf_c;

  always_comb begin
    fc    = ctl_s[NI];
    qmr_c = fc.qov_r ? CAP : qr_s[NI];
    qmi_c = fc.qov_i ? CAP : qi_s[NI];
    fr_c  = sat_m(qmr_c, fc.neg_r);
    fi_c  = sat_m(qmi_c, fc.neg_i);
    fs_c  = sat_m(sroot_s[NI], 1'b0);
    dbz_c = 1'b0;
    case (fc.mode)
      cau_pkg::MODE_DIV: begin
        if (fc.dbz) begin
          yr_c  = '0;
          yi_c  = '0;
          ovf_c = 1'b0;
          dbz_c = 1'b1;
        end else begin
          yr_c  = fr_c[EW-1:0];
          yi_c  = fi_c[EW-1:0];
          ovf_c = fr_c[EW] | fi_c[EW];
        end
      end
      cau_pkg::MODE_MAG: begin
        yr_c  = fs_c[EW-1:0];
        yi_c  = '0;
        ovf_c = fs_c[EW];
      end
      default: begin
        yr_c  = dyr_s[NI];
        yi_c  = dyi_s[NI];
        ovf_c = fc.dovf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= fc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_yr  <= yr_c;
      f_yi  <= yi_c;
      f_dbz <= dbz_c;
      f_ovf <= ovf_c;
    end
  end

  // output register and skid
  logic                 f_arr;
  logic signed [EW-1:0] o_yr, o_yi, k_yr, k_yi;
  logic                 o_dbz, o_ovf, k_dbz, k_ovf;

  assign f_arr = en && f_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (skid_v) begin
        skid_v <= 1'b0;
      end else begin
        out_valid <= f_arr;
      end
    end else if (!out_valid) begin
      out_valid <= f_arr;
    end else if (f_arr) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall && skid_v) begin
      o_yr  <= k_yr;
      o_yi  <= k_yi;
      o_dbz <= k_dbz;
      o_ovf <= k_ovf;
    end else if (f_arr && (!out_valid || !out_stall)) begin
      o_yr  <= f_yr;
      o_yi  <= f_yi;
      o_dbz <= f_dbz;
      o_ovf <= f_ovf;
    end
    if (f_arr && out_valid && out_stall) begin
      k_yr  <= f_yr;
      k_yi  <= f_yi;
      k_dbz <= f_dbz;
      k_ovf <= f_ovf;
    end
  end

  assign y_real         = 32'(o_yr);
  assign y_imag         = 32'(o_yi);
  assign divide_by_zero = o_dbz;
  assign overflow       = o_ovf;

  `CAU_ASSERT_IMP(a_skid_needs_out, clk, rst, skid_v, out_valid)
  `CAU_ASSERT_NXT(a_skid_drains, clk, rst, skid_v && !out_stall, !skid_v)
  `CAU_ASSERT_IMP(a_dbz_clean, clk, rst, out_valid && divide_by_zero, !overflow && y_real == '0 && y_imag == '0)

endmodule

// File: test/tb_complex_arithmetic_unit_top.sv
// Testbench for complex_arithmetic_unit_top: directed and random beats, a
// built-in predictor of every mode, in-order compare. Depends on cau_pkg and complex_arithmetic_unit_top.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit_top;

  typedef struct {
    logic [2:0]         mode;
    logic signed [31:0] ar, ai, br, bi, sc;
    bit                 drain;
  } op_t;

  typedef struct {
    logic signed [31:0] yr, yi;
    logic               dbz, ovf;
  } res_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] mode = '0;
  logic signed [31:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0, scalar = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] y_real, y_imag;
  logic divide_by_zero, overflow;

  op_t  pend_ops[$];
  res_t expected_res[$];
  int   errors = 0;
  int   cycles = 0;
  int   beats_in = 0;
  int   hold_cnt = 0;
  bit   hold_done = 0;
  int   src_gap = 0;
  int   snk_gap = 0;
  bit   calm = 0;

  complex_arithmetic_unit_top dut (.*);

  always #2 clk = ~clk;

  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] r, t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic res_t calc_result(input op_t o);
    res_t r;
    logic signed [127:0] ar, ai, br, bi, sc, d, nr, ni, q;
    logic ovf;
    ar = o.ar; ai = o.ai; br = o.br; bi = o.bi; sc = o.sc;
    ovf = 0;
    r.dbz = 0;
    r.yr = 0;
    r.yi = 0;
    case (o.mode)
      cau_pkg::MODE_ADD: begin
        r.yr = clamp32(ar + br, ovf);
        r.yi = clamp32(ai + bi, ovf);
      end
      cau_pkg::MODE_SUB: begin
        r.yr = clamp32(ar - br, ovf);
        r.yi = clamp32(ai - bi, ovf);
      end
      cau_pkg::MODE_MUL: begin
        r.yr = clamp32((ar * br - ai * bi) >>> 16, ovf);
        r.yi = clamp32((ar * bi + ai * br) >>> 16, ovf);
      end
      cau_pkg::MODE_SCALE: begin
        r.yr = clamp32((ar * sc) >>> 16, ovf);
        r.yi = clamp32((ai * sc) >>> 16, ovf);
      end
      cau_pkg::MODE_CONJ: begin
        r.yr = clamp32(ar, ovf);
        r.yi = clamp32(-ai, ovf);
      end
      cau_pkg::MODE_NEG: begin
        r.yr = clamp32(-ar, ovf);
        r.yi = clamp32(-ai, ovf);
      end
      cau_pkg::MODE_DIV: begin
        if (br == 0 && bi == 0) begin
          r.dbz = 1;
        end else begin
          d = br * br + bi * bi;
          nr = ar * br + ai * bi;
          ni = br * ai - ar * bi;
          // quotient truncates toward zero
          q = ((nr < 0 ? -nr : nr) <<< 16) / d;
          r.yr = clamp32(nr < 0 ? -q : q, ovf);
          q = ((ni < 0 ? -ni : ni) <<< 16) / d;
          r.yi = clamp32(ni < 0 ? -q : q, ovf);
        end
      end
      default: begin
        nr = ar * ar + ai * ai;
        q = {64'd0, isqrt(nr[63:0])};
        r.yr = clamp32(q, ovf);
        r.yi = 0;
      end
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 0;
      3, 4: return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
      5: return $signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_op(input logic [2:0] m, input logic [31:0] ar, ai, br, bi, sc,
                        input bit drain = 0);
    op_t o;
    o.mode = m; o.ar = ar; o.ai = ai; o.br = br; o.bi = bi; o.sc = sc; o.drain = drain;
    pend_ops.push_back(o);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    calm <= ((cycles / 300) % 4) == 3;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sender
  always @(posedge clk) begin
    op_t o;
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        o.mode = mode; o.ar = a_real; o.ai = a_imag; o.br = b_real; o.bi = b_imag;
        o.sc = scalar;
        expected_res.push_back(calc_result(o));
        beats_in <= beats_in + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid <= 0;
        end else if (pend_ops.size() > 0 && !(pend_ops[0].drain &&
                     (expected_res.size() > 0 || in_valid))) begin
          o = pend_ops.pop_front();
          mode <= o.mode; a_real <= o.ar; a_imag <= o.ai;
          b_real <= o.br; b_imag <= o.bi; scalar <= o.sc;
          in_valid <= 1;
          src_gap <= pick_gap();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst && !hold_done && beats_in >= 150) begin
      hold_done <= 1;
      hold_cnt <= 300;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver
  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_res.size() == 0) begin
          $error("unexpected beat y_real=%0d y_imag=%0d", y_real, y_imag);
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (y_real !== e.yr) begin
            $error("y_real expected %0d got %0d", e.yr, y_real);
            errors++;
          end
          if (y_imag !== e.yi) begin
            $error("y_imag expected %0d got %0d", e.yi, y_imag);
            errors++;
          end
          if (divide_by_zero !== e.dbz) begin
            $error("divide_by_zero expected %0b got %0b", e.dbz, divide_by_zero);
            errors++;
          end
          if (overflow !== e.ovf) begin
            $error("overflow expected %0b got %0b", e.ovf, overflow);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        out_stall <= 1;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_stall <= 1;
      end else begin
        snk_gap <= pick_gap();
        out_stall <= 0;
      end
    end
  end

  initial begin
    logic [31:0] mx, mn;
    logic [2:0] m;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    add_op(cau_pkg::MODE_ADD, mx, mn, mx, mn, 0);
    add_op(cau_pkg::MODE_SUB, mn, mx, mx, mn, 0);
    add_op(cau_pkg::MODE_SUB, 32'h00030000, 32'hfffe0000, 32'h00010000, 32'h00008000, 0);
    add_op(cau_pkg::MODE_MUL, mx, mn, mx, mn, 0);
    add_op(cau_pkg::MODE_MUL, 32'h00018000, 32'hffff0001, 32'h00020000, 32'h00000003, 0);
    add_op(cau_pkg::MODE_SCALE, mn, mx, 0, 0, mn);
    add_op(cau_pkg::MODE_SCALE, 32'hffffffff, 32'h00000001, 0, 0, 32'h00000001);
    add_op(cau_pkg::MODE_CONJ, mn, mn, mx, mx, mx);
    add_op(cau_pkg::MODE_CONJ, 32'h12345678, mx, 0, 0, 0);
    add_op(cau_pkg::MODE_NEG, mn, mx, 0, 0, 0);
    add_op(cau_pkg::MODE_DIV, mx, mn, 0, 0, mx);
    add_op(cau_pkg::MODE_DIV, 0, 0, 0, 0, 0);
    add_op(cau_pkg::MODE_DIV, mx, mx, 32'h00000001, 0, 0);
    add_op(cau_pkg::MODE_DIV, mn, mn, mn, mn, 0);
    add_op(cau_pkg::MODE_DIV, 32'h00030000, 32'hfffc0000, 32'h00010000, 32'h00020000, 0);
    add_op(cau_pkg::MODE_DIV, 32'hffff0000, 0, 0, 32'hfffd0000, 0);
    add_op(cau_pkg::MODE_MAG, mn, mn, 0, 0, 0);
    add_op(cau_pkg::MODE_MAG, mx, 0, 0, 0, 0);
    add_op(cau_pkg::MODE_MAG, 32'h00030000, 32'hfffc0000, 0, 0, 0);
    add_op(cau_pkg::MODE_MAG, 0, 0, mx, mn, mx);
    for (int i = 0; i < 640; i++) begin
      m = $urandom_range(0, 7);
      if (m == cau_pkg::MODE_DIV && $urandom_range(0, 9) == 0)
        add_op(m, rand_word(), rand_word(), 0, 0, rand_word(), i == 400);
      else
        add_op(m, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), i == 400);
    end
    repeat (10) @(posedge clk);
    rst <= 0;
    wait (pend_ops.size() == 0 && !in_valid && expected_res.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
